// ===== hdl/psma_pkg.sv =====
// ============================================================================
// psma_pkg
// Shared types, codes and default constants for the paged sparse memory.
// ============================================================================
package psma_pkg;

    // Default geometry: sixteen pages of 64 KiB each.
    localparam int PAGE_SLOTS_DEF       = 16;
    localparam int PAGE_OFFSET_BITS_DEF = 16;

    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;

    // Access direction.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Access size codes.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;  // write one zero word of the clearing sweep
        logic latch;     // capture the accepted input transfer
        logic lookup;    // compare the tag against all mapped slots
        logic alloc;     // resolve the slot, allocate on a miss
        logic read;      // issue the page word read
        logic merge;     // form the result and write back the merged word
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;  // the sweep writes its last word this cycle
    } dp_status_t;

endpackage

// ===== hdl/paged_sparse_memory_access.sv =====
// ============================================================================
// paged_sparse_memory_access
// Little-endian sparse memory built from a few pages allocated on first touch.
// ============================================================================
// Usage:
// The input channel (in_valid / in_stall) carries one access per transfer:
// opcode, address, access_size and write_data. The output channel
// (out_valid / out_stall) returns exactly one result per access: the
// zero-extended load value and the out_of_pages flag.
// An access runs through five steps: the input transfer, a parallel tag
// compare, slot resolution with allocation on a miss, a read of the page
// word store, and the merge step that forms the result and writes a merged
// word back. The block takes no new access until the current one has
// finished its merge step, in which the result register is loaded.
// After reset the block runs a clearing pass that writes zero to every
// page word, one word per cycle, PAGE_SLOTS * 2^(PAGE_OFFSET_BITS-2) words
// in all (262144 at the defaults); in_stall stays high until it ends.
// Reset also maps page 0 into slot 0 and empties the result register.
// When the receiver stalls, the result is held and the block still takes
// the next input transfer; that access waits in its merge cycle until the
// result register frees up.
// ============================================================================
module paged_sparse_memory_access #(
    parameter int PAGE_SLOTS       = psma_pkg::PAGE_SLOTS_DEF,
    parameter int PAGE_OFFSET_BITS = psma_pkg::PAGE_OFFSET_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [psma_pkg::ADDR_W-1:0] address,
    input  logic [1:0]                  access_size,
    input  logic [psma_pkg::DATA_W-1:0] write_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [psma_pkg::DATA_W-1:0] read_data,
    output logic                        out_of_pages
);

    // Commands and status between the sequencer and the datapath.
    psma_pkg::ctrl_cmd_t  cmd;
    psma_pkg::dp_status_t status;

    // The controller owns the handshakes and the access sequence.
    psma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath holds the page table, the word store and the result.
    psma_datapath #(
        .PAGE_SLOTS       (PAGE_SLOTS),
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (opcode),
        .address      (address),
        .access_size  (access_size),
        .write_data   (write_data),
        .read_data    (read_data),
        .out_of_pages (out_of_pages)
    );

endmodule

// ===== hdl/psma_ram.sv =====
// ============================================================================
// psma_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module psma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/psma_datapath.sv =====
// ============================================================================
// psma_datapath
// Tag table, slot allocation, page word store and byte lane merge.
// ============================================================================
module psma_datapath #(
    parameter int PAGE_SLOTS       = psma_pkg::PAGE_SLOTS_DEF,
    parameter int PAGE_OFFSET_BITS = psma_pkg::PAGE_OFFSET_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  psma_pkg::ctrl_cmd_t       cmd,
    output psma_pkg::dp_status_t      status,
    input  logic                      opcode,
    input  logic [psma_pkg::ADDR_W-1:0] address,
    input  logic [1:0]                access_size,
    input  logic [psma_pkg::DATA_W-1:0] write_data,
    output logic [psma_pkg::DATA_W-1:0] read_data,
    output logic                      out_of_pages
);

    localparam int SLOT_W     = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
    localparam int TAG_W      = psma_pkg::ADDR_W - PAGE_OFFSET_BITS;
    localparam int WOFF_W     = PAGE_OFFSET_BITS - 2;
    localparam int RAM_DEPTH  = PAGE_SLOTS * (1 << WOFF_W);
    localparam int RAM_AW     = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PAGE_SLOTS - 1);
    localparam logic [RAM_AW-1:0] LAST_WORD = RAM_AW'(RAM_DEPTH - 1);

    // Latched input transfer.
    logic                          op_reg;
    logic [psma_pkg::ADDR_W-1:0]   addr_reg;
    logic [1:0]                    size_reg;
    logic [psma_pkg::DATA_W-1:0]   wdata_reg;

    // Page table.
    logic [TAG_W-1:0]    tags_reg [PAGE_SLOTS];
    logic [SLOT_W-1:0]   count_reg;
    logic [PAGE_SLOTS-1:0] hit_vec_reg;
    logic [PAGE_SLOTS-1:0] hit_vec_next;
    logic [SLOT_W-1:0]   slot_enc;
    logic [SLOT_W-1:0]   slot_new;
    logic                hit_any;
    logic                room;
    logic [SLOT_W-1:0]   slot_reg;
    logic                ok_reg;

    // Clearing sweep.
    logic [RAM_AW-1:0]   clr_cnt_reg;

    // Word store access.
    logic [RAM_AW-1:0]           acc_addr;
    logic [psma_pkg::DATA_W-1:0] word;
    logic [psma_pkg::DATA_W-1:0] merged;
    logic [psma_pkg::DATA_W-1:0] load_val;
    logic [psma_pkg::DATA_W-1:0] byte_mask;
    logic [4:0]                  lane_sh;
    logic                        merge_we;
    logic                        ram_we;
    logic [RAM_AW-1:0]           ram_waddr;
    logic [psma_pkg::DATA_W-1:0] ram_wdata;

    // Result register.
    logic [psma_pkg::DATA_W-1:0] rdata_reg;
    logic                        oop_reg;

    logic [TAG_W-1:0] cur_tag;

    assign cur_tag = addr_reg[psma_pkg::ADDR_W-1:PAGE_OFFSET_BITS];

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= opcode;
            addr_reg  <= address;
            size_reg  <= access_size;
            wdata_reg <= write_data;
        end
    end

    // Every mapped slot is compared in parallel; mapped tags are unique.
    always_comb
    begin
        for (int i = 0; i < PAGE_SLOTS; i++)
        begin
            hit_vec_next[i] = (SLOT_W'(i) <= count_reg) && (tags_reg[i] == cur_tag);
        end
    end

    always_comb
    begin
        slot_enc = '0;
        for (int i = 0; i < PAGE_SLOTS; i++)
        begin
            if (hit_vec_reg[i])
            begin
                slot_enc = slot_enc | SLOT_W'(i);
            end
        end
    end

    assign hit_any  = |hit_vec_reg;
    assign room     = (count_reg != LAST_SLOT);
    assign slot_new = SLOT_W'(count_reg + 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_vec_reg <= hit_vec_next;
        end
        if (cmd.alloc)
        begin
            slot_reg <= hit_any ? slot_enc : slot_new;
            ok_reg   <= hit_any || room;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < PAGE_SLOTS; i++)
            begin
                tags_reg[i] <= '0;
            end
        end
        else if (cmd.alloc && !hit_any && room)
        begin
            count_reg          <= slot_new;
            tags_reg[slot_new] <= cur_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clr_cnt_reg <= RAM_AW'(clr_cnt_reg + 1'b1);
        end
    end

    assign status.clear_done = (clr_cnt_reg == LAST_WORD);

    assign acc_addr = RAM_AW'({slot_reg, addr_reg[PAGE_OFFSET_BITS-1:2]});

    // Byte lane shift and store merge.
    assign lane_sh   = {addr_reg[1:0], 3'b000};
    assign byte_mask = 32'h0000_00ff << lane_sh;

    always_comb
    begin
        merged   = word;
        load_val = '0;
        case (size_reg)
            psma_pkg::SIZE_WORD:
            begin
                merged   = wdata_reg;
                load_val = word;
            end
            psma_pkg::SIZE_HALF:
            begin
                if (addr_reg[1])
                begin
                    merged   = {wdata_reg[15:0], word[15:0]};
                    load_val = {16'h0000, word[31:16]};
                end
                else
                begin
                    merged   = {word[31:16], wdata_reg[15:0]};
                    load_val = {16'h0000, word[15:0]};
                end
            end
            psma_pkg::SIZE_BYTE:
            begin
                merged   = ((wdata_reg << lane_sh) & byte_mask) | (word & ~byte_mask);
                load_val = {24'h000000, 8'(word >> lane_sh)};
            end
            default:
            begin
                merged   = word;
                load_val = '0;
            end
        endcase
    end

    assign merge_we = cmd.merge && ok_reg && (op_reg == psma_pkg::OP_WRITE)
                      && (size_reg inside {psma_pkg::SIZE_BYTE, psma_pkg::SIZE_HALF,
                                           psma_pkg::SIZE_WORD});

    assign ram_we    = cmd.clear_en || merge_we;
    assign ram_waddr = cmd.clear_en ? clr_cnt_reg : acc_addr;
    assign ram_wdata = cmd.clear_en ? '0 : merged;

    psma_ram #(
        .WIDTH (psma_pkg::DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_words (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.read),
        .rd_addr (acc_addr),
        .rd_data (word)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.merge)
        begin
            rdata_reg <= (ok_reg && (op_reg == psma_pkg::OP_READ)) ? load_val : '0;
            oop_reg   <= !ok_reg;
        end
    end

    assign read_data    = rdata_reg;
    assign out_of_pages = oop_reg;

    // At most one mapped slot may carry a given tag.
    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> $onehot0(hit_vec_reg))
        else $error("more than one page slot matched the tag");

    // Pages are never released.
    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg >= $past(count_reg)))
        else $error("page count decreased");

    // A failed lookup never produces load data.
    a_oop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.merge) && oop_reg |-> (rdata_reg == '0))
        else $error("out of pages result carries data");

endmodule

// ===== hdl/psma_ctrl.sv =====
// ============================================================================
// psma_ctrl
// Sequencer: clearing sweep, then lookup, allocate, read and merge per access.
// ============================================================================
module psma_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output psma_pkg::ctrl_cmd_t  cmd,
    input  psma_pkg::dp_status_t status
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOOKUP = 3'd2;
    localparam logic [2:0] ST_ALLOC  = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_MERGE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_ALLOC;
            end
            ST_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (out_free)
                begin
                    cmd.merge  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.merge)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
